// File: src/gfd_pkg.sv
`timescale 1ns / 1ps

package gfd_pkg;

    // one payload character after offset removal
    typedef logic [5:0] t_char6;

    // character counter, saturating
    typedef logic [3:0] t_count;

    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] CHAR_OFFSET  = 8'h20;
    localparam int         FRAME_LEN    = 10;
    localparam t_count     FRAME_COUNT  = 4'd10;
    localparam t_count     SUM_COUNT    = 4'd9;
    localparam t_count     COUNT_MAX    = 4'd15;
    localparam logic [7:0] STICK_CENTER = 8'd127;

endpackage

// File: src/gfd_if.sv
`timescale 1ns / 1ps

// serial character channel
interface gfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// decoded frame result channel
interface gfd_res_if;
    logic        valid;
    logic        ready;
    logic        frame_good;
    logic [15:0] buttons;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;

    modport source (
        output valid, output frame_good, output buttons,
        output left_x, output left_y, output right_x, output right_y,
        input ready
    );
    modport sink (
        input valid, input frame_good, input buttons,
        input left_x, input left_y, input right_x, input right_y,
        output ready
    );
endinterface

// File: src/gamepad_frame_decoder_core.sv
`timescale 1ns / 1ps

// Gamepad frame decoder. Takes one serial character per cycle on i_rx; a frame is ten
// payload characters (each carrying 6 bits as char - 0x20) closed by a newline. Every
// newline gives one result on o_res: frame_good is set when exactly ten characters came
// before it and the 6-bit sum of the first nine equals the tenth, and then the held
// buttons and stick positions are updated; otherwise they are reported unchanged. The
// characters move through a row of ten 6-bit cells while a running checksum builds up,
// so the check and unpack are done as the newline is taken and the block accepts a
// character in every cycle; input stalls only while a result waits untaken on o_res.
// After reset the buttons read 0 and each stick reads 127.
module gamepad_frame_decoder_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gfd_rx_if.sink    i_rx,
    gfd_res_if.source o_res
);

    localparam int NumCells = gfd_pkg::FRAME_LEN;

    logic            w_in_xfer;
    logic            w_newline;
    logic            w_shift;
    logic [7:0]      w_diff;
    gfd_pkg::t_char6 w_char;
    gfd_pkg::t_char6 w_cell [NumCells];
    gfd_pkg::t_char6 w_s    [NumCells];
    logic            w_good;

    gfd_pkg::t_count r_count, n_count;
    gfd_pkg::t_char6 r_sum, n_sum;
    logic            r_out_valid;
    logic            r_good;
    logic [15:0]     r_buttons;
    logic [7:0]      r_left_x, r_left_y, r_right_x, r_right_y;

    // input handshake: a waiting result blocks only until it is taken
    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign w_in_xfer  = i_rx.valid && i_rx.ready;
    assign w_newline  = (i_rx.rx_byte == gfd_pkg::NEWLINE_CHAR);
    assign w_shift    = w_in_xfer && !w_newline;
    assign w_diff     = i_rx.rx_byte - gfd_pkg::CHAR_OFFSET;
    assign w_char     = w_diff[5:0];

    // shift line: newest character in cell 0, first character of a frame in the last cell
    gfd_cell u_cell0 (
        .i_clk   (i_clk),
        .i_shift (w_shift),
        .i_d     (w_char),
        .o_q     (w_cell[0])
    );

    generate
        for (genvar k = 1; k < NumCells; k++) begin : g_chain
            gfd_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_d     (w_cell[k-1]),
                .o_q     (w_cell[k])
            );
        end
    endgenerate

    // frame order view: character k of the frame
    always_comb begin
        for (int k = 0; k < NumCells; k++) begin
            w_s[k] = w_cell[NumCells - 1 - k];
        end
    end

    // character count and running checksum of the first nine characters
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        if (w_in_xfer && w_newline) begin
            n_count = '0;
            n_sum   = '0;
        end else if (w_shift) begin
            if (r_count < gfd_pkg::COUNT_MAX) begin
                n_count = r_count + 4'd1;
            end
            if (r_count < gfd_pkg::SUM_COUNT) begin
                n_sum = r_sum + w_char;
            end
        end
    end

    assign w_good = (r_count == gfd_pkg::FRAME_COUNT) && (r_sum == w_s[NumCells - 1]);

    // held values and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_buttons   <= '0;
            r_left_x    <= gfd_pkg::STICK_CENTER;
            r_left_y    <= gfd_pkg::STICK_CENTER;
            r_right_x   <= gfd_pkg::STICK_CENTER;
            r_right_y   <= gfd_pkg::STICK_CENTER;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
            if (w_in_xfer && w_newline) begin
                r_out_valid <= 1'b1;
                if (w_good) begin
                    r_buttons <= {w_s[2][3:0], w_s[1], w_s[0]};
                    r_left_x  <= {w_s[4][1:0], w_s[3]};
                    r_left_y  <= {w_s[5][3:0], w_s[4][5:2]};
                    r_right_x <= {w_s[6], w_s[5][5:4]};
                    r_right_y <= {w_s[8][1:0], w_s[7]};
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // good flag travels with the result
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && w_newline) begin
            r_good <= w_good;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.frame_good = r_good;
    assign o_res.buttons    = r_buttons;
    assign o_res.left_x     = r_left_x;
    assign o_res.left_y     = r_left_y;
    assign o_res.right_x    = r_right_x;
    assign o_res.right_y    = r_right_y;

endmodule

// File: src/gfd_cell.sv
`timescale 1ns / 1ps

// one stage of the character shift line
module gfd_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  gfd_pkg::t_char6 i_d,
    output gfd_pkg::t_char6 o_q
);

    gfd_pkg::t_char6 r_q;

    // take the neighbor's character on every stored transfer
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int STREAM_CHARS = 840;

    typedef struct packed {
        logic        good;
        logic [15:0] buttons;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
    } t_frame_res;

    typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_STALL} t_ready_mode;

    // frame predictor and expected result store
    class frame_scoreboard;
        gfd_pkg::t_count char_cnt;
        gfd_pkg::t_char6 payload[gfd_pkg::FRAME_LEN];
        t_frame_res      held;
        t_frame_res      expected_frames[$];
        int              errors;

        function new();
            char_cnt = '0;
            foreach (payload[k]) payload[k] = '0;
            held.good    = 1'b0;
            held.buttons = '0;
            held.left_x  = gfd_pkg::STICK_CENTER;
            held.left_y  = gfd_pkg::STICK_CENTER;
            held.right_x = gfd_pkg::STICK_CENTER;
            held.right_y = gfd_pkg::STICK_CENTER;
            errors = 0;
        endfunction

        // accepted character transfer: store payload or close the frame
        function void note_char(logic [7:0] ch);
            logic [7:0] sum;
            t_frame_res res;
            if (ch != gfd_pkg::NEWLINE_CHAR) begin
                if (char_cnt < gfd_pkg::FRAME_COUNT)
                    payload[char_cnt] = gfd_pkg::t_char6'(ch - gfd_pkg::CHAR_OFFSET);
                if (char_cnt < gfd_pkg::COUNT_MAX)
                    char_cnt = char_cnt + 1'b1;
            end else begin
                res = held;
                res.good = 1'b0;
                if (char_cnt == gfd_pkg::FRAME_COUNT) begin
                    sum = '0;
                    for (int k = 0; k < 9; k++)
                        sum = sum + 8'(payload[k]);
                    // checksum good: unpack buttons and sticks
                    if (sum[5:0] == payload[9]) begin
                        held.buttons = {payload[2][3:0], payload[1], payload[0]};
                        held.left_x  = {payload[4][1:0], payload[3]};
                        held.left_y  = {payload[5][3:0], payload[4][5:2]};
                        held.right_x = {payload[6], payload[5][5:4]};
                        held.right_y = {payload[8][1:0], payload[7]};
                        res = held;
                        res.good = 1'b1;
                    end
                end
                char_cnt = '0;
                expected_frames.push_back(res);
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // accepted result transfer against the oldest expectation
        function void check_frame(t_frame_res got);
            t_frame_res want;
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            compare_field("frame_good", 16'(want.good), 16'(got.good));
            compare_field("buttons", want.buttons, got.buttons);
            compare_field("left_x", 16'(want.left_x), 16'(got.left_x));
            compare_field("left_y", 16'(want.left_y), 16'(got.left_y));
            compare_field("right_x", 16'(want.right_x), 16'(got.right_x));
            compare_field("right_y", 16'(want.right_y), 16'(got.right_y));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    gfd_rx_if  rx_ch ();
    gfd_res_if res_ch ();

    gamepad_frame_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    frame_scoreboard frame_sb = new();
    logic [7:0]      char_stream[$];
    t_frame_res      res_seen;
    int              stall_cycles = 0;

    // clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // any byte whose 6-bit payload is v, never a newline
    function automatic logic [7:0] encode_char(gfd_pkg::t_char6 v);
        logic [7:0] ch;
        ch = {2'b00, v} + gfd_pkg::CHAR_OFFSET + 8'($urandom_range(0, 3) * 64);
        if (ch == gfd_pkg::NEWLINE_CHAR)
            ch = ch + 8'd64;
        return ch;
    endfunction

    // frame of n characters then newline; fill < 0 gives random payload
    task automatic push_frame(int n_chars, bit corrupt, int fill);
        gfd_pkg::t_char6 v;
        logic [7:0]      sum;
        sum = '0;
        for (int k = 0; k < n_chars; k++) begin
            if (k == gfd_pkg::FRAME_LEN - 1 && n_chars == gfd_pkg::FRAME_LEN) begin
                v = sum[5:0];
                if (corrupt)
                    v = v ^ gfd_pkg::t_char6'($urandom_range(1, 63));
            end else if (fill >= 0) begin
                v = gfd_pkg::t_char6'(fill);
            end else begin
                v = gfd_pkg::t_char6'($urandom);
            end
            sum = sum + 8'(v);
            char_stream.push_back(encode_char(v));
        end
        char_stream.push_back(gfd_pkg::NEWLINE_CHAR);
    endtask

    // raw bytes, newlines among them, then a closing newline
    task automatic push_noise(int n_chars);
        for (int k = 0; k < n_chars; k++)
            char_stream.push_back(8'($urandom_range(0, 255)));
        char_stream.push_back(gfd_pkg::NEWLINE_CHAR);
    endtask

    // sender: bursts of transfers with random gaps
    task automatic drive_chars();
        int burst_left;
        int gap;
        burst_left = 0;
        foreach (char_stream[idx]) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    @(negedge i_clk);
                    rx_ch.valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 12);
            end
            @(negedge i_clk);
            rx_ch.valid   <= 1'b1;
            rx_ch.rx_byte <= char_stream[idx];
            do @(posedge i_clk); while (!(rx_ch.valid && rx_ch.ready));
            burst_left--;
        end
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
    endtask

    // receiver stall pattern
    initial begin
        t_ready_mode mode;
        int          len;
        res_ch.ready = 1'b0;
        forever begin
            mode = t_ready_mode'($urandom_range(0, 2));
            len  = $urandom_range(1, 30);
            repeat (len) begin
                @(negedge i_clk);
                case (mode)
                    RDY_ALWAYS: res_ch.ready <= 1'b1;
                    RDY_RANDOM: res_ch.ready <= 1'($urandom_range(0, 1));
                    default:    res_ch.ready <= 1'b0;
                endcase
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rx_ch.valid && rx_ch.ready)
                frame_sb.note_char(rx_ch.rx_byte);
            if (res_ch.valid && res_ch.ready) begin
                res_seen.good    = res_ch.frame_good;
                res_seen.buttons = res_ch.buttons;
                res_seen.left_x  = res_ch.left_x;
                res_seen.left_y  = res_ch.left_y;
                res_seen.right_x = res_ch.right_x;
                res_seen.right_y = res_ch.right_y;
                frame_sb.check_frame(res_seen);
            end
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL gamepad_frame_decoder_core");
                $finish;
            end
        end
    end

    initial begin
        int sel;
        i_rst_n       = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;

        // directed: lone newline, short frame, all-zero and all-ones data before the checksum
        push_frame(0, 1'b0, -1);
        push_frame(3, 1'b0, -1);
        push_frame(gfd_pkg::FRAME_LEN, 1'b0, 0);
        push_frame(gfd_pkg::FRAME_LEN, 1'b0, 63);

        // random: mostly good frames, some corrupt, short, long and noise
        while (char_stream.size() < STREAM_CHARS) begin
            sel = $urandom_range(0, 99);
            if (sel < 62)
                push_frame(gfd_pkg::FRAME_LEN, 1'b0, -1);
            else if (sel < 72)
                push_frame(gfd_pkg::FRAME_LEN, 1'b1, -1);
            else if (sel < 80)
                push_frame($urandom_range(0, gfd_pkg::FRAME_LEN - 1), 1'b0, -1);
            else if (sel < 89)
                push_frame($urandom_range(gfd_pkg::FRAME_LEN + 1, 20), 1'b0, -1);
            else if (sel < 94)
                push_frame(gfd_pkg::FRAME_LEN, 1'b0, $urandom_range(0, 1) * 63);
            else
                push_noise($urandom_range(1, 14));
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        drive_chars();

        // drain outstanding results
        while (frame_sb.expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (frame_sb.errors == 0)
            $display("PASS gamepad_frame_decoder_core");
        else
            $display("FAIL gamepad_frame_decoder_core");
        $finish;
    end

endmodule
